// ----- design/pft_pkg.sv -----
// ----------------------------------------------------------------------------
// pft_pkg
// types and constants shared by the property file tokenizer modules
// ----------------------------------------------------------------------------
package pft_pkg;

    // token kinds as seen on the result channel
    localparam logic [3:0] K_ID_CHAR   = 4'd0;
    localparam logic [3:0] K_ID_END    = 4'd1;
    localparam logic [3:0] K_STR_BEGIN = 4'd2;
    localparam logic [3:0] K_STR_CHAR  = 4'd3;
    localparam logic [3:0] K_STR_END   = 4'd4;
    localparam logic [3:0] K_EQUALS    = 4'd5;
    localparam logic [3:0] K_COLON     = 4'd6;
    localparam logic [3:0] K_DCOLON    = 4'd7;
    localparam logic [3:0] K_LBRACE    = 4'd8;
    localparam logic [3:0] K_RBRACE    = 4'd9;
    localparam logic [3:0] K_SEMI      = 4'd10;
    localparam logic [3:0] K_ERROR     = 4'd11;
    localparam logic [3:0] K_END       = 4'd12;

    // characters the lexer looks for
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;

    typedef enum logic [3:0] {
        MODE_IDLE       = 4'd0,
        MODE_IDENT      = 4'd1,
        MODE_COLON      = 4'd2,
        MODE_SLASH      = 4'd3,
        MODE_BLOCK      = 4'd4,
        MODE_BLOCK_STAR = 4'd5,
        MODE_LINE       = 4'd6,
        MODE_STRING     = 4'd7,
        MODE_ESCAPE     = 4'd8
    } mode_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] ch;
        logic       last;
    } event_t;

    // events produced by one request: up to two
    typedef struct packed {
        logic [1:0] num;
        event_t     ev0;
        event_t     ev1;
    } lex_out_t;

endpackage

// ----- design/pft_lexer.sv -----
// ----------------------------------------------------------------------------
// pft_lexer
// lexer mode register and per-byte token decision
// ----------------------------------------------------------------------------
module pft_lexer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        byte_value,
    input  logic              end_of_input,
    output pft_pkg::lex_out_t lex_out
);

    pft_pkg::mode_t mode_reg;
    pft_pkg::mode_t mode_next;

    logic           is_start;
    logic           is_cont;
    logic           idle_hit;
    logic [3:0]     idle_kind;
    logic [7:0]     idle_ch;
    pft_pkg::mode_t idle_mode;
    logic           flush_hit;
    logic [3:0]     flush_kind;
    logic [1:0]     num;
    logic [3:0]     k0;
    logic [3:0]     k1;
    logic [7:0]     c0;
    logic [7:0]     c1;

    assign is_start = (byte_value >= 8'h61 && byte_value <= 8'h7A)
                   || (byte_value >= 8'h41 && byte_value <= 8'h5A)
                   || (byte_value == pft_pkg::CH_UNDER);
    assign is_cont  = is_start || (byte_value >= 8'h30 && byte_value <= 8'h39);

    // handling of a byte that arrives between tokens
    always_comb begin
        idle_hit  = 1'b0;
        idle_kind = pft_pkg::K_SEMI;
        idle_ch   = 8'h00;
        idle_mode = pft_pkg::MODE_IDLE;
        unique case (byte_value)
            pft_pkg::CH_SLASH:  idle_mode = pft_pkg::MODE_SLASH;
            pft_pkg::CH_SEMI: begin
                idle_hit  = 1'b1;
                idle_kind = pft_pkg::K_SEMI;
            end
            pft_pkg::CH_LBRACE: begin
                idle_hit  = 1'b1;
                idle_kind = pft_pkg::K_LBRACE;
            end
            pft_pkg::CH_RBRACE: begin
                idle_hit  = 1'b1;
                idle_kind = pft_pkg::K_RBRACE;
            end
            pft_pkg::CH_EQUALS: begin
                idle_hit  = 1'b1;
                idle_kind = pft_pkg::K_EQUALS;
            end
            pft_pkg::CH_COLON:  idle_mode = pft_pkg::MODE_COLON;
            pft_pkg::CH_QUOTE: begin
                idle_hit  = 1'b1;
                idle_kind = pft_pkg::K_STR_BEGIN;
                idle_mode = pft_pkg::MODE_STRING;
            end
            default: begin
                if (is_start) begin
                    idle_hit  = 1'b1;
                    idle_kind = pft_pkg::K_ID_CHAR;
                    idle_ch   = byte_value;
                    idle_mode = pft_pkg::MODE_IDENT;
                end
            end
        endcase
    end

    // pending token flushed by end of input
    always_comb begin
        flush_hit  = 1'b0;
        flush_kind = pft_pkg::K_ERROR;
        unique case (mode_reg)
            pft_pkg::MODE_IDENT: begin
                flush_hit  = 1'b1;
                flush_kind = pft_pkg::K_ID_END;
            end
            pft_pkg::MODE_COLON: begin
                flush_hit  = 1'b1;
                flush_kind = pft_pkg::K_COLON;
            end
            pft_pkg::MODE_STRING, pft_pkg::MODE_ESCAPE: begin
                flush_hit  = 1'b1;
                flush_kind = pft_pkg::K_ERROR;
            end
            default: flush_hit = 1'b0;
        endcase
    end

    // next mode and events
    always_comb begin
        num       = 2'd0;
        k0        = pft_pkg::K_END;
        c0        = 8'h00;
        k1        = pft_pkg::K_END;
        c1        = 8'h00;
        mode_next = mode_reg;
        if (end_of_input) begin
            mode_next = pft_pkg::MODE_IDLE;
            if (flush_hit) begin
                k0  = flush_kind;
                num = 2'd2;
            end else begin
                num = 2'd1;
            end
        end else begin
            unique case (mode_reg)
                pft_pkg::MODE_IDENT: begin
                    if (is_cont) begin
                        k0  = pft_pkg::K_ID_CHAR;
                        c0  = byte_value;
                        num = 2'd1;
                    end else begin
                        k0        = pft_pkg::K_ID_END;
                        k1        = idle_kind;
                        c1        = idle_ch;
                        num       = idle_hit ? 2'd2 : 2'd1;
                        mode_next = idle_mode;
                    end
                end
                pft_pkg::MODE_COLON: begin
                    if (byte_value == pft_pkg::CH_COLON) begin
                        k0        = pft_pkg::K_DCOLON;
                        num       = 2'd1;
                        mode_next = pft_pkg::MODE_IDLE;
                    end else begin
                        k0        = pft_pkg::K_COLON;
                        k1        = idle_kind;
                        c1        = idle_ch;
                        num       = idle_hit ? 2'd2 : 2'd1;
                        mode_next = idle_mode;
                    end
                end
                pft_pkg::MODE_SLASH: begin
                    if (byte_value == pft_pkg::CH_STAR) begin
                        mode_next = pft_pkg::MODE_BLOCK;
                    end else if (byte_value == pft_pkg::CH_SLASH) begin
                        mode_next = pft_pkg::MODE_LINE;
                    end else begin
                        mode_next = pft_pkg::MODE_IDLE;
                    end
                end
                pft_pkg::MODE_BLOCK: begin
                    if (byte_value == pft_pkg::CH_STAR) begin
                        mode_next = pft_pkg::MODE_BLOCK_STAR;
                    end
                end
                pft_pkg::MODE_BLOCK_STAR: begin
                    if (byte_value == pft_pkg::CH_SLASH) begin
                        mode_next = pft_pkg::MODE_IDLE;
                    end else if (byte_value != pft_pkg::CH_STAR) begin
                        mode_next = pft_pkg::MODE_BLOCK;
                    end
                end
                pft_pkg::MODE_LINE: begin
                    if (byte_value == pft_pkg::CH_LF || byte_value == pft_pkg::CH_CR) begin
                        mode_next = pft_pkg::MODE_IDLE;
                    end
                end
                pft_pkg::MODE_STRING: begin
                    if (byte_value == pft_pkg::CH_BSLASH) begin
                        mode_next = pft_pkg::MODE_ESCAPE;
                    end else if (byte_value == pft_pkg::CH_QUOTE) begin
                        k0        = pft_pkg::K_STR_END;
                        num       = 2'd1;
                        mode_next = pft_pkg::MODE_IDLE;
                    end else begin
                        k0  = pft_pkg::K_STR_CHAR;
                        c0  = byte_value;
                        num = 2'd1;
                    end
                end
                pft_pkg::MODE_ESCAPE: begin
                    mode_next = pft_pkg::MODE_STRING;
                    if (byte_value == pft_pkg::CH_LOW_N) begin
                        k0  = pft_pkg::K_STR_CHAR;
                        c0  = pft_pkg::CH_LF;
                        num = 2'd1;
                    end else if (byte_value != pft_pkg::CH_LF) begin
                        k0  = pft_pkg::K_STR_CHAR;
                        c0  = byte_value;
                        num = 2'd1;
                    end
                end
                default: begin
                    k0        = idle_kind;
                    c0        = idle_ch;
                    num       = idle_hit ? 2'd1 : 2'd0;
                    mode_next = idle_mode;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= pft_pkg::MODE_IDLE;
        end else if (accept) begin
            mode_reg <= mode_next;
        end
    end

    assign lex_out.num       = num;
    assign lex_out.ev0.kind  = k0;
    assign lex_out.ev0.ch    = c0;
    assign lex_out.ev0.last  = (num == 2'd1);
    assign lex_out.ev1.kind  = k1;
    assign lex_out.ev1.ch    = c1;
    assign lex_out.ev1.last  = (num == 2'd2);

endmodule

// ----- design/pft_evq.sv -----
// ----------------------------------------------------------------------------
// pft_evq
// four-entry token event queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module pft_evq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  pft_pkg::lex_out_t lex_out,
    output logic              has_room,
    output logic              out_valid,
    input  logic              out_ready,
    output pft_pkg::event_t   out_event
);

    pft_pkg::event_t entry_reg [4];
    logic [1:0]      wr_ptr_reg;
    logic [1:0]      rd_ptr_reg;
    logic [2:0]      count_reg;
    logic [2:0]      count_next;
    logic [1:0]      n_push;
    logic            pop;

    assign pop       = out_valid && out_ready;
    assign n_push    = push ? lex_out.num : 2'd0;
    assign out_valid = (count_reg != 3'd0);
    assign has_room  = (count_reg <= 3'd2);
    assign out_event = entry_reg[rd_ptr_reg];
    assign count_next = count_reg + {1'b0, n_push} - {2'b00, pop};

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            entry_reg[wr_ptr_reg] <= lex_out.ev0;
        end
        if (n_push == 2'd2) begin
            entry_reg[wr_ptr_reg + 2'd1] <= lex_out.ev1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + n_push;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            count_reg  <= count_next;
        end
    end

endmodule

// ----- design/property_file_tokenizer.sv -----
// ----------------------------------------------------------------------------
// property_file_tokenizer
// byte-at-a-time tokenizer for a brace-structured property text format
// ----------------------------------------------------------------------------
// The tokenizer takes one byte (or an end-of-input marker) per request and
// answers with zero, one or two token events on the m_ channel. Identifier
// characters stream out one by one and close with an id-end event; strings
// come as begin, character and end events with backslash escapes resolved;
// the punctuation tokens = : :: { } ; each give one event. Comments and
// stray bytes give nothing. End of input flushes any pending token and then
// gives an end event (an error event first if a string is still open).
// m_last_of_run marks the last event caused by a request. Rate: a request is
// taken every cycle while the four-entry event queue holds at most two
// events; the lexer decision is combinational logic on the mode register.
// Sustained throughput is one event per cycle on the output side while m_ready
// is high, so bytes that give two events take longer than bytes that give none.
// ----------------------------------------------------------------------------
module property_file_tokenizer (
    input  logic       aclk,
    input  logic       aresetn,
    // input requests
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_value,
    input  logic       s_end_of_input,
    // token events
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_token_kind,
    output logic [7:0] m_char_value,
    output logic       m_last_of_run
);

    pft_pkg::lex_out_t lex_out;
    pft_pkg::event_t   out_event;
    logic              accept;
    logic              has_room;

    // room for a full pair of events decides ready, never the lexer mode
    assign s_ready = has_room;
    assign accept  = s_valid && s_ready;

    // mode register plus the per-byte token decision
    pft_lexer u_lexer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .byte_value   (s_byte_value),
        .end_of_input (s_end_of_input),
        .lex_out      (lex_out)
    );

    // events wait here so the output side can stall without losing a byte
    pft_evq u_evq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .lex_out   (lex_out),
        .has_room  (has_room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_event (out_event)
    );

    assign m_token_kind  = out_event.kind;
    assign m_char_value  = out_event.ch;
    assign m_last_of_run = out_event.last;

endmodule

// ----- design/pft_checker.sv -----
// ----------------------------------------------------------------------------
// pft_checker
// port-level checks for the property file tokenizer
// ----------------------------------------------------------------------------
module pft_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_token_kind,
    input logic [7:0] m_char_value,
    input logic       m_last_of_run
);

    // nothing comes out right after reset
    a_quiet_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("event shown right after reset");

    // a stalled event holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_token_kind)
            && $stable(m_char_value) && $stable(m_last_of_run))
        else $error("stalled event changed");

    // only character events carry a character
    a_char_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind != pft_pkg::K_ID_CHAR
            && m_token_kind != pft_pkg::K_STR_CHAR |-> m_char_value == 8'h00)
        else $error("char value on a non-character event");

    // end of input always closes the run of its request
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind == pft_pkg::K_END |-> m_last_of_run)
        else $error("end event not last of run");

    // an idle queue always takes a request
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("not ready with an empty queue");

endmodule

bind property_file_tokenizer pft_checker u_pft_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_token_kind  (m_token_kind),
    .m_char_value  (m_char_value),
    .m_last_of_run (m_last_of_run)
);

// ----- bench/token_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_checker
// watches both channels of the tokenizer, predicts the token events of every
// accepted request and compares each delivered event against the oldest one
// ----------------------------------------------------------------------------
module token_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_byte_value,
    input  logic       s_end_of_input,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [3:0] m_token_kind,
    input  logic [7:0] m_char_value,
    input  logic       m_last_of_run,
    output int         fail_count,
    output int         pending_count,
    output int         checked_count
);

    localparam logic [7:0] CH_LOW_A  = "a";
    localparam logic [7:0] CH_LOW_Z  = "z";
    localparam logic [7:0] CH_UP_A   = "A";
    localparam logic [7:0] CH_UP_Z   = "Z";
    localparam logic [7:0] CH_DIGIT0 = "0";
    localparam logic [7:0] CH_DIGIT9 = "9";

    pft_pkg::mode_t  lex_mode;
    pft_pkg::event_t expected_tokens [$];
    pft_pkg::event_t run_events [2];
    int              run_len;
    pft_pkg::event_t want;

    function automatic logic starts_ident(input logic [7:0] c);
        return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
               c == pft_pkg::CH_UNDER;
    endfunction

    function automatic logic continues_ident(input logic [7:0] c);
        return starts_ident(c) || (c >= CH_DIGIT0 && c <= CH_DIGIT9);
    endfunction

    function automatic void add_token(input logic [3:0] k, input logic [7:0] c);
        pft_pkg::event_t ev;
        ev.kind = k;
        ev.ch   = c;
        ev.last = 1'b0;
        run_events[run_len] = ev;
        run_len++;
    endfunction

    // byte seen between tokens
    function automatic void take_idle_byte(input logic [7:0] c);
        lex_mode = pft_pkg::MODE_IDLE;
        case (c)
            pft_pkg::CH_SLASH:  lex_mode = pft_pkg::MODE_SLASH;
            pft_pkg::CH_SEMI:   add_token(pft_pkg::K_SEMI, 8'h00);
            pft_pkg::CH_LBRACE: add_token(pft_pkg::K_LBRACE, 8'h00);
            pft_pkg::CH_RBRACE: add_token(pft_pkg::K_RBRACE, 8'h00);
            pft_pkg::CH_EQUALS: add_token(pft_pkg::K_EQUALS, 8'h00);
            pft_pkg::CH_COLON:  lex_mode = pft_pkg::MODE_COLON;
            pft_pkg::CH_QUOTE: begin
                add_token(pft_pkg::K_STR_BEGIN, 8'h00);
                lex_mode = pft_pkg::MODE_STRING;
            end
            default: begin
                if (starts_ident(c)) begin
                    add_token(pft_pkg::K_ID_CHAR, c);
                    lex_mode = pft_pkg::MODE_IDENT;
                end
            end
        endcase
    endfunction

    function automatic void lex_request(input logic [7:0] c, input logic eoi);
        int i;
        run_len = 0;
        if (eoi) begin
            case (lex_mode)
                pft_pkg::MODE_IDENT:  add_token(pft_pkg::K_ID_END, 8'h00);
                pft_pkg::MODE_COLON:  add_token(pft_pkg::K_COLON, 8'h00);
                pft_pkg::MODE_STRING,
                pft_pkg::MODE_ESCAPE: add_token(pft_pkg::K_ERROR, 8'h00);
                default: ;
            endcase
            add_token(pft_pkg::K_END, 8'h00);
            lex_mode = pft_pkg::MODE_IDLE;
        end else begin
            case (lex_mode)
                pft_pkg::MODE_IDENT: begin
                    if (continues_ident(c)) begin
                        add_token(pft_pkg::K_ID_CHAR, c);
                    end else begin
                        add_token(pft_pkg::K_ID_END, 8'h00);
                        take_idle_byte(c);
                    end
                end
                pft_pkg::MODE_COLON: begin
                    if (c == pft_pkg::CH_COLON) begin
                        add_token(pft_pkg::K_DCOLON, 8'h00);
                        lex_mode = pft_pkg::MODE_IDLE;
                    end else begin
                        add_token(pft_pkg::K_COLON, 8'h00);
                        take_idle_byte(c);
                    end
                end
                pft_pkg::MODE_SLASH: begin
                    if (c == pft_pkg::CH_STAR) lex_mode = pft_pkg::MODE_BLOCK;
                    else if (c == pft_pkg::CH_SLASH) lex_mode = pft_pkg::MODE_LINE;
                    else lex_mode = pft_pkg::MODE_IDLE;
                end
                pft_pkg::MODE_BLOCK: begin
                    if (c == pft_pkg::CH_STAR) lex_mode = pft_pkg::MODE_BLOCK_STAR;
                end
                pft_pkg::MODE_BLOCK_STAR: begin
                    if (c == pft_pkg::CH_SLASH) lex_mode = pft_pkg::MODE_IDLE;
                    else if (c != pft_pkg::CH_STAR) lex_mode = pft_pkg::MODE_BLOCK;
                end
                pft_pkg::MODE_LINE: begin
                    if (c == pft_pkg::CH_LF || c == pft_pkg::CH_CR) begin
                        lex_mode = pft_pkg::MODE_IDLE;
                    end
                end
                pft_pkg::MODE_STRING: begin
                    if (c == pft_pkg::CH_BSLASH) begin
                        lex_mode = pft_pkg::MODE_ESCAPE;
                    end else if (c == pft_pkg::CH_QUOTE) begin
                        add_token(pft_pkg::K_STR_END, 8'h00);
                        lex_mode = pft_pkg::MODE_IDLE;
                    end else begin
                        add_token(pft_pkg::K_STR_CHAR, c);
                    end
                end
                pft_pkg::MODE_ESCAPE: begin
                    if (c == pft_pkg::CH_LOW_N) add_token(pft_pkg::K_STR_CHAR, pft_pkg::CH_LF);
                    else if (c != pft_pkg::CH_LF) add_token(pft_pkg::K_STR_CHAR, c);
                    lex_mode = pft_pkg::MODE_STRING;
                end
                default: take_idle_byte(c);
            endcase
        end
        if (run_len > 0) run_events[run_len - 1].last = 1'b1;
        for (i = 0; i < run_len; i++) expected_tokens = {expected_tokens, run_events[i]};
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            lex_mode = pft_pkg::MODE_IDLE;
            expected_tokens.delete();
            fail_count    = 0;
            checked_count = 0;
        end else begin
            if (s_valid && s_ready) lex_request(s_byte_value, s_end_of_input);
            if (m_valid && m_ready) begin
                checked_count++;
                if (expected_tokens.size() == 0) begin
                    $display("%0t: unexpected token: kind %0d char %h last %b",
                             $time, m_token_kind, m_char_value, m_last_of_run);
                    fail_count++;
                end else begin
                    want = expected_tokens[0];
                    expected_tokens.delete(0);
                    if (m_token_kind !== want.kind || m_char_value !== want.ch ||
                        m_last_of_run !== want.last) begin
                        $display("%0t: token mismatch: expected kind %0d char %h last %b, %s",
                                 $time, want.kind, want.ch, want.last, "got");
                        $display("%0t:   actual kind %0d char %h last %b",
                                 $time, m_token_kind, m_char_value, m_last_of_run);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = expected_tokens.size();
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives the property file tokenizer with directed and random text
// ----------------------------------------------------------------------------
// A short directed text walks every token kind but SEMI and ERROR, the
// string escapes, both comment styles and end of input; then random fragments
// (identifiers, strings with escapes, punctuation, comments, stray bytes and
// noise, with end markers dropped in anywhere) keep the lexer busy. The source
// sends in bursts with gaps and the sink stalls on its own pattern. token_checker
// predicts and compares; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int IDLE_LIMIT   = 1000;   // cycles with no request moving
    localparam int TARGET_ITEMS = 1850;
    localparam int SETTLE       = 20;

    // sink stall styles
    localparam int SINK_OPEN = 0;   // always ready
    localparam int SINK_COIN = 1;   // ready at random
    localparam int SINK_COMB = 2;   // ready in a repeating comb pattern
    localparam int SINK_HOLD = 3;   // one long stall, then ready

    localparam logic [7:0] CH_LOW_A  = "a";
    localparam logic [7:0] CH_UP_A   = "A";
    localparam logic [7:0] CH_DIGIT0 = "0";
    localparam logic [7:0] CH_SPACE  = " ";
    localparam logic [7:0] CH_TAB    = 8'h09;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_byte_value = 8'h00;
    logic       s_end_of_input = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [3:0] m_token_kind;
    logic [7:0] m_char_value;
    logic       m_last_of_run;

    int failures;
    int tokens_pending;
    int tokens_checked;
    int items_sent = 0;
    int stream_ends = 0;
    int burst_left = 0;
    int quiet_cycles = 0;

    property_file_tokenizer uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_byte_value   (s_byte_value),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_char_value   (m_char_value),
        .m_last_of_run  (m_last_of_run)
    );

    token_checker u_token_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_byte_value   (s_byte_value),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_char_value   (m_char_value),
        .m_last_of_run  (m_last_of_run),
        .fail_count     (failures),
        .pending_count  (tokens_pending),
        .checked_count  (tokens_checked)
    );

    // 8 ns clock
    initial begin
        forever #4 aclk = ~aclk;
    end

    // one request; valid stays up across a burst, drops only for a gap
    task automatic send_item(input logic [7:0] c, input logic eoi);
        int gap;
        if (burst_left == 0) begin
            // a third of the bursts follow on with no gap at all
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_byte_value   <= c;
        s_end_of_input <= eoi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        items_sent++;
        if (eoi) stream_ends++;
    endtask

    // random byte stream: now and then an end marker lands mid-token
    task automatic send_char(input logic [7:0] c);
        logic [7:0] junk;
        junk = 8'($urandom);
        if ($urandom_range(0, 59) == 0) send_item(junk, 1'b1);
        send_item(c, 1'b0);
    endtask

    // hold the source until every predicted token has been delivered
    task automatic wait_for_tokens();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (tokens_pending != 0) @(negedge aclk);
    endtask

    function automatic logic [7:0] random_start();
        logic [7:0] r;
        r = 8'($urandom_range(0, 52));
        if (r < 8'd26) return CH_LOW_A + r;
        if (r < 8'd52) return CH_UP_A + (r - 8'd26);
        return pft_pkg::CH_UNDER;
    endfunction

    function automatic logic [7:0] random_cont();
        logic [7:0] r;
        r = 8'($urandom_range(0, 9));
        if ($urandom_range(0, 4) == 0) return CH_DIGIT0 + r;
        return random_start();
    endfunction

    // one random piece of property text; most pieces are well formed
    task automatic send_fragment();
        int pick;
        int len;
        int i;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        len  = $urandom_range(0, 10);
        if (pick < 25) begin
            // identifier, closed by whatever comes next
            send_char(random_start());
            for (i = 0; i < len; i++) send_char(random_cont());
        end else if (pick < 45) begin
            // quoted string with escapes; one in ten left open
            send_char(pft_pkg::CH_QUOTE);
            for (i = 0; i < len; i++) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_char(pft_pkg::CH_BSLASH);
                    case ($urandom_range(0, 3))
                        0:       b = pft_pkg::CH_LOW_N;
                        1:       b = pft_pkg::CH_LF;
                        default: b = 8'($urandom);
                    endcase
                    send_char(b);
                end else begin
                    b = 8'($urandom);
                    if (b == pft_pkg::CH_QUOTE || b == pft_pkg::CH_BSLASH) begin
                        b = pft_pkg::CH_UNDER;
                    end
                    send_char(b);
                end
            end
            if ($urandom_range(0, 9) != 0) send_char(pft_pkg::CH_QUOTE);
        end else if (pick < 65) begin
            // punctuation
            case ($urandom_range(0, 6))
                0: send_char(pft_pkg::CH_SEMI);
                1: send_char(pft_pkg::CH_LBRACE);
                2: send_char(pft_pkg::CH_RBRACE);
                3: send_char(pft_pkg::CH_EQUALS);
                4: send_char(pft_pkg::CH_COLON);
                default: begin
                    send_char(pft_pkg::CH_COLON);
                    send_char(pft_pkg::CH_COLON);
                end
            endcase
        end else if (pick < 73) begin
            // block comment, closed by a run of stars and a slash
            send_char(pft_pkg::CH_SLASH);
            send_char(pft_pkg::CH_STAR);
            for (i = 0; i < len; i++) begin
                b = 8'($urandom);
                if ($urandom_range(0, 3) == 0) b = pft_pkg::CH_STAR;
                send_char(b);
            end
            len = $urandom_range(1, 3);
            for (i = 0; i < len; i++) send_char(pft_pkg::CH_STAR);
            send_char(pft_pkg::CH_SLASH);
        end else if (pick < 80) begin
            // line comment, closed by newline or carriage return
            send_char(pft_pkg::CH_SLASH);
            send_char(pft_pkg::CH_SLASH);
            for (i = 0; i < len; i++) begin
                b = 8'($urandom);
                if (b == pft_pkg::CH_LF || b == pft_pkg::CH_CR) b = CH_SPACE;
                send_char(b);
            end
            send_char($urandom_range(0, 1) ? pft_pkg::CH_LF : pft_pkg::CH_CR);
        end else if (pick < 88) begin
            // whitespace and digits between tokens
            case ($urandom_range(0, 3))
                0:       b = CH_SPACE;
                1:       b = CH_TAB;
                2:       b = pft_pkg::CH_LF;
                default: b = CH_DIGIT0 + 8'($urandom_range(0, 9));
            endcase
            send_char(b);
        end else if (pick < 97) begin
            // raw noise
            b = 8'($urandom);
            send_char(b);
        end else begin
            b = 8'($urandom);
            send_item(b, 1'b1);
        end
    endtask

    // sink: a new stall style every so often
    initial begin
        int style;
        int span;
        int hold;
        int k;
        forever begin
            style = $urandom_range(SINK_OPEN, SINK_HOLD);
            span  = $urandom_range(20, 200);
            hold  = $urandom_range(5, 24);
            for (k = 0; k < span; k++) begin
                @(negedge aclk);
                case (style)
                    SINK_OPEN: m_ready <= 1'b1;
                    SINK_COIN: m_ready <= 1'($urandom_range(0, 1));
                    SINK_COMB: m_ready <= (k % 3 != 2);
                    default:   m_ready <= (k >= hold);
                endcase
            end
        end
    end

    // watchdog on cycles where neither channel moves a request
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog: nothing moved for %0d cycles", $time, IDLE_LIMIT);
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial begin
        bit paused;
        paused = 1'b0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: identifier with every char class, closed by equals
        send_item("a", 1'b0);
        send_item("Z", 1'b0);
        send_item("9", 1'b0);
        send_item(pft_pkg::CH_UNDER, 1'b0);
        send_item(pft_pkg::CH_EQUALS, 1'b0);
        // double colon, then colon flushed by a brace
        send_item(pft_pkg::CH_COLON, 1'b0);
        send_item(pft_pkg::CH_COLON, 1'b0);
        send_item(pft_pkg::CH_COLON, 1'b0);
        send_item(pft_pkg::CH_LBRACE, 1'b0);
        send_item(pft_pkg::CH_RBRACE, 1'b0);
        // string: backslash-n, backslash-newline, escaped quote, top byte
        send_item(pft_pkg::CH_QUOTE, 1'b0);
        send_item(pft_pkg::CH_BSLASH, 1'b0);
        send_item(pft_pkg::CH_LOW_N, 1'b0);
        send_item(pft_pkg::CH_BSLASH, 1'b0);
        send_item(pft_pkg::CH_LF, 1'b0);
        send_item(pft_pkg::CH_BSLASH, 1'b0);
        send_item(pft_pkg::CH_QUOTE, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(pft_pkg::CH_QUOTE, 1'b0);
        // block comment closed by a star run
        send_item(pft_pkg::CH_SLASH, 1'b0);
        send_item(pft_pkg::CH_STAR, 1'b0);
        send_item(pft_pkg::CH_STAR, 1'b0);
        send_item(pft_pkg::CH_STAR, 1'b0);
        send_item(pft_pkg::CH_SLASH, 1'b0);
        // line comment closed by carriage return, then a stray byte and end of input
        send_item(pft_pkg::CH_SLASH, 1'b0);
        send_item(pft_pkg::CH_SLASH, 1'b0);
        send_item(pft_pkg::CH_CR, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);

        // random text
        while (items_sent < TARGET_ITEMS) begin
            send_fragment();
            if (!paused && items_sent >= TARGET_ITEMS / 2) begin
                wait_for_tokens();
                paused = 1'b1;
            end
        end

        // drain, then give stragglers time to show up
        wait_for_tokens();
        repeat (SETTLE) @(negedge aclk);

        $display("%0d requests sent, %0d of them end markers; %0d token events checked",
                 items_sent, stream_ends, tokens_checked);
        $display("text mixed tokens, escapes, comments and noise under bursty source and sink");
        if (failures == 0 && tokens_pending == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/pft_pkg.sv
design/pft_lexer.sv
design/pft_evq.sv
design/property_file_tokenizer.sv
design/pft_checker.sv
bench/token_checker.sv
bench/testbench.sv
